// ===== hw/rtl/spr_pkg.sv =====
package spr_pkg;

    localparam int SINE_BITS = 10;
    localparam int QTAB_LAST = 256;
    localparam int FRAME_BITS = 16;
    localparam int MAX_FRAMES = 65536;
    localparam int MAX_OUT_CH = 8;
    localparam logic [31:0] TEAR_THR = 32'd3006477108;
    localparam logic [31:0] CRAB_THR = 32'd1288490189;
    localparam logic [31:0] NOTCH_THR = 32'd85899346;
    localparam logic [31:0] QUARTER = 32'd1073741824;
    localparam logic [31:0] THREE_QUARTER = 32'd3221225472;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_PATTERN    = 3'd0,
        REG_PHASE_STEP = 3'd1,
        REG_RATE_RATIO = 3'd2,
        REG_FRAME_CNT  = 3'd3,
        REG_OUT_CH     = 3'd4,
        REG_TRACK_CH   = 3'd5
    } t_reg;

    typedef enum logic [3:0] {
        PAT_BABY      = 4'd0,
        PAT_SCRIBBLE  = 4'd1,
        PAT_TEAR      = 4'd2,
        PAT_CHIRP     = 4'd3,
        PAT_FLARE     = 4'd4,
        PAT_ORBIT     = 4'd5,
        PAT_TRANSFORM = 4'd6,
        PAT_CRAB      = 4'd7,
        PAT_TWIDDLE   = 4'd8,
        PAT_HYDRO     = 4'd9
    } t_pattern;

    typedef enum logic [3:0] {
        S_IDLE, S_SIN_A, S_SIN_B, S_TWID, S_RATE, S_POS,
        S_RD0, S_RD1, S_RD2, S_INTP, S_EMIT, S_WAIT
    } t_state;

    typedef logic [15:0] t_qtab [0:QTAB_LAST];

    // Quarter-wave sine in Q1.15 from an odd polynomial in Q2.30.
    function automatic logic [15:0] quarter_sin(input int m);
        logic [63:0] x, x2, t, s, r;
        begin
            x = (64'(m) * 64'd6746518852) >> SINE_BITS;
            x2 = (x * x) >> 30;
            t = 64'd1073741824 - x2 / 72;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
            s = (x * t) >> 30;
            r = (s + 64'd16384) >> 15;
            if (r > 64'd32767) r = 64'd32767;
            return r[15:0];
        end
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab q;
        begin
            for (int k = 0; k <= QTAB_LAST; k++) q[k] = quarter_sin(k);
            return q;
        end
    endfunction

    localparam t_qtab QTAB = build_qtab();

    function automatic logic signed [15:0] sin_q15(input logic [31:0] phase);
        logic [9:0] k;
        logic [8:0] idx;
        logic       neg;
        logic [15:0] v;
        begin
            k = phase[31:32-SINE_BITS];
            neg = 1'b0;
            if (k <= 10'd256) begin
                idx = k[8:0];
            end else if (k <= 10'd512) begin
                idx = 9'(10'd512 - k);
            end else if (k <= 10'd768) begin
                idx = 9'(k - 10'd512);
                neg = 1'b1;
            end else begin
                idx = 9'(11'd1024 - {1'b0, k});
                neg = 1'b1;
            end
            v = QTAB[idx];
            return neg ? -$signed(v) : $signed(v);
        end
    endfunction

endpackage

// ===== hw/rtl/scratch_pattern_resampler.sv =====
// Variable-speed sample player driven by scratch patterns.
// Input stream: tuser carries the command (load, start, render); tdata packs
// load_frame, load_channel, load_sample and start_position. A load writes one
// sample into the 64K x 2 track memory, a start sets the play position and
// clears the pattern phase, a render advances the position and emits one
// interpolated sample per output channel on the output stream, with tlast on
// the final channel. The user must write configuration registers through the
// plain write port only while the block is idle, which it does not enforce.
// Load and start take effect when accepted. A render forms the speed and
// position in S_SIN_A, S_RATE and S_POS (with S_SIN_B and S_TWID added for
// the twiddle pattern), all through one shared 25x25 multiplier and one sine
// table read per cycle, then steps through S_RD0 to S_WAIT for each output
// channel (two memory reads, one multiply, one output register).
// The input is not ready while a render is in progress; if the receiver
// stalls, the block holds the current sample until it is taken.
// Reset clears position, phase and registers to their defaults; the track
// memory is not cleared and must be loaded before it is played.
module scratch_pattern_resampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // load_frame[15:0], load_channel[16], load_sample[32:17], start_position[64:33]
    input  logic [71:0] i_s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // sample_out[15:0], channel_out[18:16]
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);
    import spr_pkg::*;

    logic [3:0]  r_pattern;
    logic [31:0] r_phase_step;
    logic [23:0] r_rate;
    logic [16:0] r_frame_cnt;
    logic [3:0]  r_out_ch;
    logic [1:0]  r_track_ch;

    t_state      r_state, n_state;
    logic [31:0] r_play;
    logic [31:0] r_phase;
    logic signed [15:0] r_sa, r_sb;
    logic signed [49:0] r_prod;
    logic [2:0]  r_ch;
    logic signed [15:0] r_s0, r_s1;
    logic [15:0] r_rdata;
    logic        r_tvalid;
    logic [15:0] r_tsample;
    logic [2:0]  r_tch;
    logic        r_tlast;

    logic [15:0] mem [0:2*MAX_FRAMES-1];

    // Saturated configuration.
    logic [16:0] nf;
    logic [31:0] maxpos;
    logic [2:0]  last_ch;
    logic        two_tracks;
    always_comb begin
        if (r_frame_cnt == 17'd0) nf = 17'd1;
        else if (r_frame_cnt > 17'(MAX_FRAMES)) nf = 17'(MAX_FRAMES);
        else nf = r_frame_cnt;
        maxpos = {16'(nf - 17'd1), 16'd0} ;
        if (r_out_ch == 4'd0) last_ch = 3'd0;
        else if (r_out_ch > 4'(MAX_OUT_CH)) last_ch = 3'(MAX_OUT_CH - 1);
        else last_ch = 3'(r_out_ch - 4'd1);
        two_tracks = (r_track_ch >= 2'd2);
    end

    logic accept;
    logic t_cmd_is_render;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign t_cmd_is_render = (i_s_axis_tuser == CMD_RENDER);

    // Phase for the table lookup of the selected pattern.
    logic [31:0] sin_ph;
    always_comb begin
        case (r_pattern)
            PAT_SCRIBBLE: sin_ph = r_phase << 4;
            PAT_ORBIT:    sin_ph = r_phase + (r_phase << 1);
            PAT_TWIDDLE:  sin_ph = r_phase << 3;
            PAT_HYDRO:    sin_ph = r_phase << 1;
            default:      sin_ph = r_phase << 2;
        endcase
    end

    // Speed in Q16 frames per output sample.
    logic signed [19:0] speed;
    logic [31:0] p4, p6, p8, p12, p24, d1, d3;
    logic signed [51:0] tw3;
    always_comb begin
        p4 = r_phase << 2;
        p8 = r_phase << 3;
        p6 = (r_phase << 2) + (r_phase << 1);
        p12 = p6 << 1;
        p24 = p6 << 2;
        d1 = (p4 >= QUARTER) ? p4 - QUARTER : QUARTER - p4;
        d3 = (p4 >= THREE_QUARTER) ? p4 - THREE_QUARTER : THREE_QUARTER - p4;
        tw3 = ({r_prod[49], r_prod, 1'b0}) + {{2{r_prod[49]}}, r_prod};
        case (r_pattern)
            PAT_BABY:      speed = 20'(r_sa) <<< 2;
            PAT_SCRIBBLE:  speed = (20'(r_sa) <<< 1) + 20'(r_sa);
            PAT_TEAR:      speed = (p8 < TEAR_THR) ? 20'sd131072 : -20'sd196608;
            PAT_CHIRP:     speed = p6[31] ? 20'sd0 : 20'sd196608;
            PAT_FLARE:     speed = (d1 < NOTCH_THR || d3 < NOTCH_THR) ? 20'sd0
                                   : (20'(r_sa) <<< 2);
            PAT_ORBIT:     speed = (20'(r_sa) <<< 2) + 20'(r_sa);
            PAT_TRANSFORM: speed = p12[31] ? 20'sd0 : 20'sd131072;
            PAT_CRAB:      speed = (p24 < CRAB_THR) ? 20'sd131072 : 20'sd0;
            PAT_TWIDDLE:   speed = 20'(tw3 >>> 15);
            PAT_HYDRO:     speed = (20'(r_sa) <<< 2) + (20'(r_sa) <<< 1);
            default:       speed = 20'sd0;
        endcase
    end

    // The one shared multiplier.
    logic signed [24:0] mul_a, mul_b;
    logic signed [16:0] diff;
    assign diff = 17'(r_s1) - 17'(r_s0);
    always_comb begin
        case (r_state)
            S_TWID: begin
                mul_a = 25'(r_sa);
                mul_b = 25'(r_sb);
            end
            S_RATE: begin
                mul_a = 25'(speed);
                mul_b = $signed({1'b0, r_rate});
            end
            default: begin
                mul_a = 25'(diff);
                mul_b = $signed({9'd0, r_play[15:0]});
            end
        endcase
    end

    // New position, clamped to the track.
    logic signed [33:0] pos;
    logic [31:0] pos_cl;
    always_comb begin
        pos = $signed({2'b00, r_play}) + 34'(r_prod >>> 16);
        if (pos < 0) pos_cl = 32'd0;
        else if (pos > $signed({2'b00, maxpos})) pos_cl = maxpos;
        else pos_cl = pos[31:0];
    end

    // Memory read address.
    logic [15:0] f0, f1;
    logic        src;
    logic [16:0] raddr;
    always_comb begin
        f0 = r_play[31:16];
        f1 = (17'(f0) + 17'd1 < nf) ? f0 + 16'd1 : 16'(nf - 17'd1);
        src = two_tracks && (r_ch != 3'd0);
        raddr = (r_state == S_RD1) ? {f1, src} : {f0, src};
    end

    logic signed [17:0] interp;
    assign interp = 18'(r_s0) + 18'(r_prod >>> 16);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && t_cmd_is_render) n_state = S_SIN_A;
            S_SIN_A: n_state = (r_pattern == PAT_TWIDDLE) ? S_SIN_B : S_RATE;
            S_SIN_B: n_state = S_TWID;
            S_TWID:  n_state = S_RATE;
            S_RATE:  n_state = S_POS;
            S_POS:   n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_INTP;
            S_INTP:  n_state = S_EMIT;
            S_EMIT:  n_state = S_WAIT;
            S_WAIT: begin
                if (i_m_axis_tready) n_state = r_tlast ? S_IDLE : S_RD0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_s_axis_tuser == CMD_LOAD)
            mem[{i_s_axis_tdata[15:0], i_s_axis_tdata[16]}] <= i_s_axis_tdata[32:17];
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= 4'd0;
            r_phase_step <= 32'd44739;
            r_rate <= 24'd65536;
            r_frame_cnt <= 17'd65536;
            r_out_ch <= 4'd2;
            r_track_ch <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PATTERN:    r_pattern <= i_cfg_data[3:0];
                REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                REG_RATE_RATIO: r_rate <= i_cfg_data[23:0];
                REG_FRAME_CNT:  r_frame_cnt <= i_cfg_data[16:0];
                REG_OUT_CH:     r_out_ch <= i_cfg_data[3:0];
                REG_TRACK_CH:   r_track_ch <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play <= 32'd0;
            r_phase <= 32'd0;
            r_tvalid <= 1'b0;
            r_ch <= 3'd0;
        end else begin
            if (accept && i_s_axis_tuser == CMD_START) begin
                r_play <= i_s_axis_tdata[64:33];
                r_phase <= 32'd0;
            end
            if (r_state == S_POS) begin
                r_play <= pos_cl;
                r_phase <= r_phase + r_phase_step;
                r_ch <= 3'd0;
            end
            if (r_state == S_EMIT) r_tvalid <= 1'b1;
            if (r_state == S_WAIT && i_m_axis_tready) begin
                r_tvalid <= 1'b0;
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    // The first frame's sample is in the read register during S_RD1,
    // the next frame's during S_RD2.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SIN_A) r_sa <= sin_q15(sin_ph);
        if (r_state == S_SIN_B) r_sb <= sin_q15(r_phase + QUARTER);
        if (r_state == S_TWID || r_state == S_RATE || r_state == S_INTP)
            r_prod <= mul_a * mul_b;
        if (r_state == S_RD1) r_s0 <= r_rdata;
        if (r_state == S_RD2) r_s1 <= r_rdata;
        if (r_state == S_EMIT) begin
            r_tsample <= interp[15:0];
            r_tch <= r_ch;
            r_tlast <= (r_ch == last_ch);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata = {5'd0, r_tch, r_tsample};
    assign o_m_axis_tlast = r_tlast;

`ifndef NO_ASSERTIONS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while a result is pending");
    a_render_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd_is_render) |=> (r_state == S_SIN_A))
        else $error("render transaction did not start the sequencer");
    a_pos_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (r_play <= maxpos))
        else $error("play position outside the track");
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_tch <= last_ch && o_m_axis_tvalid))
        else $error("output channel beyond the configured count");
`endif

endmodule
